@@ rtl/c3_pkg.sv @@
package c3_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_KERNEL = 2'd0;
  localparam logic [1:0] REG_DIV9   = 2'd1;
  localparam logic [1:0] REG_WIDTH  = 2'd2;

  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 63;
  localparam int KERNEL_W    = 63;
  localparam int WIDTH_REG_W = 11;

  localparam logic [WIDTH_REG_W-1:0] WIDTH_RESET = 11'd1024;
  localparam int MIN_WIDTH = 3;

  // window taps, row-major, tap zero is the oldest row and column
  localparam int TAPS = 9;

  localparam logic [7:0] PIX_MAX = 8'd255;

  // x / 9 == (x * DIV9_MUL) >> DIV9_SHIFT for every x below 2**18
  localparam logic [17:0] DIV9_MUL   = 18'd233017;
  localparam int          DIV9_SHIFT = 21;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_t;

  typedef struct packed {
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
    logic       frame_start;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       row_end;
  } out_item_t;

  // control that rides along the pipeline with each item
  typedef struct packed {
    logic valid;
    logic last;
  } ctl_t;

endpackage

@@ rtl/conv3x3_rgb_clamp.sv @@
// path: a pixel's result passes the line buffer read, the window, nine
// multiply-add cells, the clamp and the output register
// throughput: one pixel per clock unless a result waits, set by one read and
// one write of each line buffer per pixel; border pixels give no result
// reset: configuration to defaults, counters, window and valid flags cleared,
// line buffers keep their contents and need no clearing pass
module conv3x3_rgb_clamp
  import c3_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int COEFF_BITS = 7
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_item,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int SW = COEFF_BITS + 12;
  localparam int DW = SW + 17;

  logic [KERNEL_W-1:0]    kernel_coefficients;
  logic                   divide_by_nine;
  logic [WIDTH_REG_W-1:0] image_width;

  logic en;

  ctl_t                  ctl_s [TAPS+1];
  pix_t [TAPS-1:0]       win_s [TAPS+1];
  logic signed [SW-1:0]  sum_s [TAPS+1][3];

  logic [DW-1:0] dprod [3];
  logic [SW-1:0] val   [3];
  logic [7:0]    res   [3];

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_coefficients <= '0;
      divide_by_nine      <= 1'b0;
      image_width         <= WIDTH_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_KERNEL: kernel_coefficients <= cfg_data[KERNEL_W-1:0];
        REG_DIV9:   divide_by_nine      <= cfg_data[0];
        REG_WIDTH:  image_width         <= cfg_data[WIDTH_REG_W-1:0];
        default:    ;
      endcase
    end
  end

  // whole pipeline advances unless a result waits
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  c3_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (in_valid),
    .in_item    (in_item),
    .image_width(image_width),
    .win        (win_s[0]),
    .win_ctl    (ctl_s[0])
  );

  // chain of multiply-add cells, one tap each
  for (genvar k = 0; k < TAPS; k++) begin : g_cell
    if (k == 0) begin : g_zero
      for (genvar c = 0; c < 3; c++) begin : g_ch
        assign sum_s[0][c] = '0;
      end
    end
    c3_cell #(
      .COEFF_BITS(COEFF_BITS)
    ) u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .coeff($signed(kernel_coefficients[k*COEFF_BITS +: COEFF_BITS])),
      .ctl_i(ctl_s[k]),
      .win_i(win_s[k]),
      .sum_i(sum_s[k]),
      .ctl_o(ctl_s[k+1]),
      .win_o(win_s[k+1]),
      .sum_o(sum_s[k+1])
    );
  end

  // optional divide by nine, then clamp to the pixel range
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      dprod[c] = DW'(sum_s[TAPS][c][SW-2:0]) * DW'(DIV9_MUL);
      val[c]   = divide_by_nine ? SW'(dprod[c] >> DIV9_SHIFT) : sum_s[TAPS][c];
      if (sum_s[TAPS][c][SW-1]) begin
        res[c] = 8'd0;
      end else if (val[c] > SW'(PIX_MAX)) begin
        res[c] = PIX_MAX;
      end else begin
        res[c] = val[c][7:0];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= ctl_s[TAPS].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item.out_red   <= res[0];
      out_item.out_green <= res[1];
      out_item.out_blue  <= res[2];
      out_item.row_end   <= ctl_s[TAPS].last;
    end
  end

  a_window_used: assert property (@(posedge clk) disable iff (rst)
    ctl_s[TAPS].valid |-> win_s[TAPS] == '0)
    else $error("window not fully consumed by the cells");

  a_chain_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(ctl_s[TAPS]) && $stable(sum_s[TAPS][0]))
    else $error("cell chain moved while a result waits");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    en |=> out_valid == $past(ctl_s[TAPS].valid))
    else $error("result flag lost at the output register");

endmodule

@@ rtl/c3_front.sv @@
module c3_front
  import c3_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  in_item_t               in_item,
  input  logic [WIDTH_REG_W-1:0] image_width,
  output pix_t [TAPS-1:0]        win,
  output ctl_t                   win_ctl
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int LW = ((WW > WIDTH_REG_W) ? WW : WIDTH_REG_W) + 1;

  // line buffers
  pix_t upper_mem [MAX_WIDTH];
  pix_t lower_mem [MAX_WIDTH];

  logic [CW-1:0] column_count;
  logic [1:0]    rows_seen;

  logic [CW-1:0] col;
  logic [1:0]    rows;
  logic [LW-1:0] width_eff;
  logic          last;
  logic          emit;

  // stage a: item with its line buffer reads
  logic          a_valid;
  logic [CW-1:0] a_col;
  pix_t          a_pix;
  logic          a_emit;
  logic          a_last;
  pix_t          up_rd;
  pix_t          lo_rd;
  logic          byp;
  pix_t          byp_up;
  pix_t          byp_lo;
  pix_t          up_eff;
  pix_t          lo_eff;

  // effective width clamped to the supported range
  always_comb begin
    width_eff = LW'(image_width);
    if (width_eff < LW'(MIN_WIDTH)) begin
      width_eff = LW'(MIN_WIDTH);
    end else if (width_eff > LW'(MAX_WIDTH)) begin
      width_eff = LW'(MAX_WIDTH);
    end
  end

  // position of the incoming item
  always_comb begin
    col  = in_item.frame_start ? '0 : column_count;
    rows = in_item.frame_start ? 2'd0 : rows_seen;
    if ({1'b0, col} >= (CW + 1)'(MAX_WIDTH)) begin
      col = '0;
    end
    last = (LW'(col) + LW'(1)) >= width_eff;
    emit = rows[1] && (col >= CW'(2));
  end

  // row and column tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      rows_seen    <= 2'd0;
      a_valid      <= 1'b0;
    end else if (en) begin
      a_valid <= in_valid;
      if (in_valid) begin
        column_count <= last ? '0 : col + CW'(1);
        rows_seen    <= (last && !rows[1]) ? rows + 2'd1 : rows;
      end
    end
  end

  // stage a payload, forward when the previous item writes the same column
  always_ff @(posedge clk) begin
    if (en) begin
      a_col  <= col;
      a_pix  <= pix_t'({in_item.in_red, in_item.in_green, in_item.in_blue});
      a_emit <= emit;
      a_last <= last;
      byp    <= a_valid && (col == a_col);
      byp_up <= lo_eff;
      byp_lo <= a_pix;
    end
  end

  assign up_eff = byp ? byp_up : up_rd;
  assign lo_eff = byp ? byp_lo : lo_rd;

  // line buffer reads
  always_ff @(posedge clk) begin
    if (en) begin
      up_rd <= upper_mem[col];
      lo_rd <= lower_mem[col];
    end
  end

  // line buffer writes: the lower row moves up, the new pixel goes below
  always_ff @(posedge clk) begin
    if (en && a_valid) begin
      upper_mem[a_col] <= lo_eff;
      lower_mem[a_col] <= a_pix;
    end
  end

  // 3x3 window shifts one column per item
  always_ff @(posedge clk) begin
    if (rst) begin
      win     <= '0;
      win_ctl <= '0;
    end else if (en) begin
      win_ctl.valid <= a_valid && a_emit;
      win_ctl.last  <= a_last;
      if (a_valid) begin
        for (int r = 0; r < 3; r++) begin
          win[r*3]     <= win[r*3+1];
          win[r*3+1]   <= win[r*3+2];
        end
        win[2] <= up_eff;
        win[5] <= lo_eff;
        win[8] <= a_pix;
      end
    end
  end

  a_col_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, column_count} < (CW + 1)'(MAX_WIDTH))
    else $error("column count out of range");

  a_win_follows: assert property (@(posedge clk) disable iff (rst)
    en && a_valid |=> win_ctl.valid == $past(a_emit))
    else $error("window result flag lost");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(column_count) && $stable(rows_seen) && $stable(a_valid))
    else $error("front advanced during stall");

endmodule

@@ rtl/c3_cell.sv @@
module c3_cell
  import c3_pkg::*;
#(
  parameter int COEFF_BITS = 7
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic signed [COEFF_BITS-1:0] coeff,
  input  ctl_t                         ctl_i,
  input  pix_t [TAPS-1:0]              win_i,
  input  logic signed [COEFF_BITS+11:0] sum_i [3],
  output ctl_t                         ctl_o,
  output pix_t [TAPS-1:0]              win_o,
  output logic signed [COEFF_BITS+11:0] sum_o [3]
);

  localparam int SW = COEFF_BITS + 12;
  localparam int PW = COEFF_BITS + 9;

  logic signed [PW-1:0] prod [3];

  // weigh the head pixel of the window
  always_comb begin
    prod[0] = $signed({1'b0, win_i[0].red})   * coeff;
    prod[1] = $signed({1'b0, win_i[0].green}) * coeff;
    prod[2] = $signed({1'b0, win_i[0].blue})  * coeff;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_o <= '0;
    end else if (en) begin
      ctl_o <= ctl_i;
    end
  end

  // pass the rest of the window and the partial sums on
  always_ff @(posedge clk) begin
    if (en) begin
      win_o <= win_i >> $bits(pix_t);
      for (int c = 0; c < 3; c++) begin
        sum_o[c] <= sum_i[c] + SW'(prod[c]);
      end
    end
  end

endmodule
